// ===== hdl/rmo_pkg.sv =====
// Shared types and constants for the rotation matrix orthonormaliser.
// Element format, internal datapath widths, stage counts and status codes.
// No dependencies.
package rmo_pkg;

	// Element format: signed Q4.28
	localparam int ELEM_W = 32;
	localparam int FRAC_W = 28;

	// Operand magnitude must hold both an input magnitude and a unit magnitude
	localparam int MAG_W  = (ELEM_W > FRAC_W + 1) ? ELEM_W : FRAC_W + 1;
	localparam int UNIT_W = FRAC_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SH_W   = $clog2(PROD_W + 1);

	// Cross product magnitudes are brought below 2^NRM_W before squaring
	localparam int NRM_W  = 31;
	localparam int SQ_W   = 2 * NRM_W + 2;
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 1;
	localparam int QUO_W  = FRAC_W + 2;

	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = QUO_W;
	// products, difference, abs, shift search, shift, squares, sum, root, divide, round
	localparam int UC_LAT = 7 + SQRT_STEPS + DIV_STEPS + 1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_X_FAIL = 2'd1,
		STAT_Y_FAIL = 2'd2,
		STAT_Z_FAIL = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] col0_x;
		logic signed [ELEM_W-1:0] col0_y;
		logic signed [ELEM_W-1:0] col0_z;
		logic signed [ELEM_W-1:0] col1_x;
		logic signed [ELEM_W-1:0] col1_y;
		logic signed [ELEM_W-1:0] col1_z;
		logic signed [ELEM_W-1:0] col2_x;
		logic signed [ELEM_W-1:0] col2_y;
		logic signed [ELEM_W-1:0] col2_z;
	} mat_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] fix0_x;
		logic signed [ELEM_W-1:0] fix0_y;
		logic signed [ELEM_W-1:0] fix0_z;
		logic signed [ELEM_W-1:0] fix1_x;
		logic signed [ELEM_W-1:0] fix1_y;
		logic signed [ELEM_W-1:0] fix1_z;
		logic signed [ELEM_W-1:0] fix2_x;
		logic signed [ELEM_W-1:0] fix2_y;
		logic signed [ELEM_W-1:0] fix2_z;
		status_t                  status;
	} fix_t;

	// Sign-magnitude vectors: operands and unit results
	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} svec_t;

	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][UNIT_W-1:0] mag;
	} uvec_t;

	typedef struct packed {
		svec_t c0;
		svec_t c1;
		svec_t c2;
	} smat_t;

endpackage

// ===== hdl/rmo_ucross.sv =====
// Pipelined unit cross product: y = unit(a x b) in sign-magnitude form.
// Exact products, common shift, squared norm, restoring square root and
// long division, one step per stage. Depends on rmo_pkg.
module rmo_ucross #(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              en,
	input  rmo_pkg::svec_t    a,
	input  rmo_pkg::svec_t    b,
	input  logic [SIDE_W-1:0] side_in,
	output rmo_pkg::uvec_t    y,
	output logic [SIDE_W-1:0] side_out
);
	import rmo_pkg::*;

	localparam int LAST_SQ = SQRT_STEPS - 1;
	localparam int LAST_DV = DIV_STEPS - 1;

	// Stage 1: six exact products
	logic [5:0][PROD_W-1:0] prod_s1;
	logic [5:0]             pneg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= PROD_W'(a.mag[1]) * PROD_W'(b.mag[2]);
			prod_s1[1] <= PROD_W'(a.mag[2]) * PROD_W'(b.mag[1]);
			prod_s1[2] <= PROD_W'(a.mag[2]) * PROD_W'(b.mag[0]);
			prod_s1[3] <= PROD_W'(a.mag[0]) * PROD_W'(b.mag[2]);
			prod_s1[4] <= PROD_W'(a.mag[0]) * PROD_W'(b.mag[1]);
			prod_s1[5] <= PROD_W'(a.mag[1]) * PROD_W'(b.mag[0]);
			pneg_s1[0] <= a.neg[1] ^ b.neg[2];
			pneg_s1[1] <= a.neg[2] ^ b.neg[1];
			pneg_s1[2] <= a.neg[2] ^ b.neg[0];
			pneg_s1[3] <= a.neg[0] ^ b.neg[2];
			pneg_s1[4] <= a.neg[0] ^ b.neg[1];
			pneg_s1[5] <= a.neg[1] ^ b.neg[0];
		end
	end

	// Stage 2: signed differences
	logic [2:0][PROD_W+1:0] crs_c, crs_s2;

	always_comb begin
		logic [PROD_W+1:0] lhs, rhs;
		for (int i = 0; i < 3; i++) begin
			lhs = {2'b00, prod_s1[2*i]};
			rhs = {2'b00, prod_s1[2*i+1]};
			crs_c[i] = (pneg_s1[2*i] ? -lhs : lhs) + (pneg_s1[2*i+1] ? rhs : -rhs);
		end
	end

	always_ff @(posedge clk) begin
		if (en) crs_s2 <= crs_c;
	end

	// Stage 3: split into sign and magnitude
	logic [2:0][PROD_W-1:0] mag_c, mag_s3;
	logic [2:0]             neg_c, neg_s3;

	always_comb begin
		logic [PROD_W+1:0] inv;
		for (int i = 0; i < 3; i++) begin
			inv      = -crs_s2[i];
			neg_c[i] = crs_s2[i][PROD_W+1];
			mag_c[i] = neg_c[i] ? inv[PROD_W-1:0] : crs_s2[i][PROD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_c;
			neg_s3 <= neg_c;
		end
	end

	// Stage 4: common right shift from the widest magnitude
	logic [PROD_W-1:0]      orv;
	logic [SH_W-1:0]        len, sh_c, sh_s4;
	logic [2:0][PROD_W-1:0] mag_s4;
	logic [2:0]             neg_s4;

	always_comb begin
		orv = mag_s3[0] | mag_s3[1] | mag_s3[2];
		len = '0;
		for (int i = 0; i < PROD_W; i++) begin
			if (orv[i]) len = SH_W'(i + 1);
		end
		sh_c = (len > SH_W'(NRM_W)) ? len - SH_W'(NRM_W) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s4  <= sh_c;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	// Stage 5: shift, truncating toward zero
	logic [2:0][NRM_W-1:0] m_c, m_s5;
	logic [2:0]            neg_s5;

	always_comb begin
		logic [PROD_W-1:0] shd;
		for (int i = 0; i < 3; i++) begin
			shd    = mag_s4[i] >> sh_s4;
			m_c[i] = shd[NRM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5   <= m_c;
			neg_s5 <= neg_s4;
		end
	end

	// Stage 6: squares; stage 7: squared norm
	logic [2:0][SQ_W-1:0]  sq_s6;
	logic [2:0][NRM_W-1:0] m_s6, m_s7;
	logic [2:0]            neg_s6, neg_s7;
	logic [SQ_W-1:0]       sum_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= SQ_W'(m_s5[i]) * SQ_W'(m_s5[i]);
			end
			m_s6   <= m_s5;
			neg_s6 <= neg_s5;
			sum_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
			m_s7   <= m_s6;
			neg_s7 <= neg_s6;
		end
	end

	// Square root: one result bit per stage
	logic [SQ_W-1:0]       sqx_s [SQRT_STEPS];
	logic [SQ_W-1:0]       sqr_s [SQRT_STEPS];
	logic [2:0][NRM_W-1:0] sqm_s [SQRT_STEPS];
	logic [2:0]            sqn_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0]       x_in, r_in, trial;
		logic [2:0][NRM_W-1:0] m_in;
		logic [2:0]            n_in;

		if (k == 0) begin : g_first
			assign x_in = sum_s7;
			assign r_in = '0;
			assign m_in = m_s7;
			assign n_in = neg_s7;
		end else begin : g_next
			assign x_in = sqx_s[k-1];
			assign r_in = sqr_s[k-1];
			assign m_in = sqm_s[k-1];
			assign n_in = sqn_s[k-1];
		end

		assign trial = r_in + STEP_BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (x_in >= trial) begin
					sqx_s[k] <= x_in - trial;
					sqr_s[k] <= (r_in >> 1) + STEP_BIT;
				end else begin
					sqx_s[k] <= x_in;
					sqr_s[k] <= r_in >> 1;
				end
				sqm_s[k] <= m_in;
				sqn_s[k] <= n_in;
			end
		end
	end

	// Long division m / n, three lanes, one quotient bit per stage
	logic [2:0][REM_W-1:0] dvr_s [DIV_STEPS];
	logic [2:0][QUO_W-1:0] dvq_s [DIV_STEPS];
	logic [ROOT_W-1:0]     dvn_s [DIV_STEPS];
	logic [2:0]            dvg_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [2:0][REM_W-1:0] r_in, r_nx;
		logic [2:0][QUO_W-1:0] q_in, q_nx;
		logic [ROOT_W-1:0]     n_in;
		logic [2:0]            g_in;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					r_in[i] = REM_W'(sqm_s[LAST_SQ][i]);
				end
			end
			assign q_in = '0;
			assign n_in = sqr_s[LAST_SQ][ROOT_W-1:0];
			assign g_in = sqn_s[LAST_SQ];
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					r_in[i] = {dvr_s[k-1][i][REM_W-2:0], 1'b0};
				end
			end
			assign q_in = dvq_s[k-1];
			assign n_in = dvn_s[k-1];
			assign g_in = dvg_s[k-1];
		end

		always_comb begin
			logic ge;
			for (int i = 0; i < 3; i++) begin
				ge      = r_in[i] >= {1'b0, n_in};
				r_nx[i] = ge ? r_in[i] - {1'b0, n_in} : r_in[i];
				q_nx[i] = {q_in[i][QUO_W-2:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvr_s[k] <= r_nx;
				dvq_s[k] <= q_nx;
				dvn_s[k] <= n_in;
				dvg_s[k] <= g_in;
			end
		end
	end

	// Round half up; a zero norm gives the zero vector
	uvec_t unit_c, unit_s;

	always_comb begin
		logic [QUO_W:0] rnd;
		for (int i = 0; i < 3; i++) begin
			rnd = {1'b0, dvq_s[LAST_DV][i]} + (QUO_W+1)'(1);
			if (dvn_s[LAST_DV] == '0) begin
				unit_c.mag[i] = '0;
				unit_c.neg[i] = 1'b0;
			end else begin
				unit_c.mag[i] = rnd[UNIT_W:1];
				unit_c.neg[i] = dvg_s[LAST_DV][i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) unit_s <= unit_c;
	end

	assign y = unit_s;

	// Side data rides alongside the datapath
	logic [SIDE_W-1:0] side_s [UC_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < UC_LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign side_out = side_s[UC_LAT-1];

endmodule

// ===== hdl/rotation_matrix_orthonormalise.sv =====
// Top level of the rotation matrix orthonormaliser: three chained unit cross
// products, the dot product checks and the output register with skid stage.
// Depends on rmo_pkg and rmo_ucross.
//
// A matrix enters on every cycle that mat_valid is high and mat_stall low, and
// its repaired columns and status leave from the output register when the
// output is not stalled. Throughput is one matrix per clock while mat_stall is
// low; the path runs through the three unit cross products in series, each with
// a 32-stage square root and a 30-stage divider for Q4.28 elements, plus decode
// and two check stages. A skid register takes one more result while fix_stall
// is high, after which mat_stall rises until the output drains.
module rotation_matrix_orthonormalise (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_stall,
	input  rmo_pkg::mat_t mat,
	output logic          fix_valid,
	input  logic          fix_stall,
	output rmo_pkg::fix_t fix
);
	import rmo_pkg::*;

	localparam int DEPTH = 1 + 3 * UC_LAT + 2;
	localparam int DP_W  = MAG_W + UNIT_W;
	localparam int DOT_W = DP_W + 3;
	localparam int EXT_W = ELEM_W + UNIT_W + 1;

	typedef struct packed {
		smat_t m;
		uvec_t f0;
	} sd1_t;

	typedef struct packed {
		smat_t m;
		uvec_t f0;
		uvec_t f1;
	} sd2_t;

	function automatic logic [MAG_W-1:0] elem_mag(input logic signed [ELEM_W-1:0] v);
		logic [MAG_W-1:0] e;
		e = MAG_W'(v);
		return v[ELEM_W-1] ? -e : e;
	endfunction

	function automatic svec_t to_sv(input logic signed [ELEM_W-1:0] vx,
			input logic signed [ELEM_W-1:0] vy, input logic signed [ELEM_W-1:0] vz);
		svec_t s;
		s.neg    = {vz[ELEM_W-1], vy[ELEM_W-1], vx[ELEM_W-1]};
		s.mag[0] = elem_mag(vx);
		s.mag[1] = elem_mag(vy);
		s.mag[2] = elem_mag(vz);
		return s;
	endfunction

	function automatic svec_t widen(input uvec_t u);
		svec_t s;
		s.neg = u.neg;
		for (int i = 0; i < 3; i++) begin
			s.mag[i] = MAG_W'(u.mag[i]);
		end
		return s;
	endfunction

	function automatic logic [ELEM_W-1:0] to_elem(input logic ng, input logic [UNIT_W-1:0] mg);
		logic [EXT_W-1:0] m, lim, inv;
		m   = EXT_W'(mg);
		lim = EXT_W'(1) << (ELEM_W - 1);
		if (!ng) lim = lim - EXT_W'(1);
		if (m > lim) m = lim;
		inv = -m;
		return ng ? inv[ELEM_W-1:0] : m[ELEM_W-1:0];
	endfunction

	// Global advance: the pipeline moves unless the skid register is full
	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic             fix_vld_q, skid_vld_q;

	assign en        = !skid_vld_q;
	assign mat_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], mat_valid};
		end
	end

	// Stage 1: decode to sign-magnitude
	smat_t mat_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1.c0 <= to_sv(mat.col0_x, mat.col0_y, mat.col0_z);
			mat_s1.c1 <= to_sv(mat.col1_x, mat.col1_y, mat.col1_z);
			mat_s1.c2 <= to_sv(mat.col2_x, mat.col2_y, mat.col2_z);
		end
	end

	// New x = unit(col1 x col2)
	uvec_t fix0_u, fix1_u, fix2_u;
	smat_t side0;
	sd1_t  side1;
	sd2_t  side2;

	rmo_ucross #(.SIDE_W($bits(smat_t))) u_cross0 (
		.clk      (clk),
		.en       (en),
		.a        (mat_s1.c1),
		.b        (mat_s1.c2),
		.side_in  (mat_s1),
		.y        (fix0_u),
		.side_out (side0)
	);

	// New y = unit(col2 x new x)
	rmo_ucross #(.SIDE_W($bits(sd1_t))) u_cross1 (
		.clk      (clk),
		.en       (en),
		.a        (side0.c2),
		.b        (widen(fix0_u)),
		.side_in  ({side0, fix0_u}),
		.y        (fix1_u),
		.side_out (side1)
	);

	// New z = unit(new x x new y)
	rmo_ucross #(.SIDE_W($bits(sd2_t))) u_cross2 (
		.clk      (clk),
		.en       (en),
		.a        (widen(side1.f0)),
		.b        (widen(fix1_u)),
		.side_in  ({side1.m, side1.f0, fix1_u}),
		.y        (fix2_u),
		.side_out (side2)
	);

	// Dot product checks: products, then sums and status
	svec_t [2:0] col_w;
	uvec_t [2:0] fx_w;

	assign col_w = {side2.m.c2, side2.m.c1, side2.m.c0};
	assign fx_w  = {fix2_u, side2.f1, side2.f0};

	logic [2:0][2:0][DP_W-1:0] dprod_s212;
	logic [2:0][2:0]           dneg_s212;
	uvec_t [2:0]               fixu_s212;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				for (int e = 0; e < 3; e++) begin
					dprod_s212[c][e] <= DP_W'(col_w[c].mag[e]) * DP_W'(fx_w[c].mag[e]);
					dneg_s212[c][e]  <= col_w[c].neg[e] ^ fx_w[c].neg[e];
				end
			end
			fixu_s212 <= fx_w;
		end
	end

	logic [2:0] pos_c;
	fix_t       res_c, res_s213, fix_q, skid_q;

	always_comb begin
		logic [DOT_W-1:0] sum, term;
		for (int c = 0; c < 3; c++) begin
			sum = '0;
			for (int e = 0; e < 3; e++) begin
				term = DOT_W'(dprod_s212[c][e]);
				sum  = sum + (dneg_s212[c][e] ? -term : term);
			end
			pos_c[c] = !sum[DOT_W-1] && (sum != '0);
		end

		res_c.fix0_x = to_elem(fixu_s212[0].neg[0], fixu_s212[0].mag[0]);
		res_c.fix0_y = to_elem(fixu_s212[0].neg[1], fixu_s212[0].mag[1]);
		res_c.fix0_z = to_elem(fixu_s212[0].neg[2], fixu_s212[0].mag[2]);
		res_c.fix1_x = to_elem(fixu_s212[1].neg[0], fixu_s212[1].mag[0]);
		res_c.fix1_y = to_elem(fixu_s212[1].neg[1], fixu_s212[1].mag[1]);
		res_c.fix1_z = to_elem(fixu_s212[1].neg[2], fixu_s212[1].mag[2]);
		res_c.fix2_x = to_elem(fixu_s212[2].neg[0], fixu_s212[2].mag[0]);
		res_c.fix2_y = to_elem(fixu_s212[2].neg[1], fixu_s212[2].mag[1]);
		res_c.fix2_z = to_elem(fixu_s212[2].neg[2], fixu_s212[2].mag[2]);

		// report the first failing column
		if (!pos_c[0])      res_c.status = STAT_X_FAIL;
		else if (!pos_c[1]) res_c.status = STAT_Y_FAIL;
		else if (!pos_c[2]) res_c.status = STAT_Z_FAIL;
		else                res_c.status = STAT_OK;
	end

	always_ff @(posedge clk) begin
		if (en) res_s213 <= res_c;
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!fix_vld_q || !fix_stall) begin
			if (skid_vld_q) begin
				fix_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				fix_vld_q <= vld_q[DEPTH-1];
			end
		end else if (en && vld_q[DEPTH-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!fix_vld_q || !fix_stall) begin
			fix_q <= skid_vld_q ? skid_q : res_s213;
		end else if (en) begin
			skid_q <= res_s213;
		end
	end

	assign fix_valid = fix_vld_q;
	assign fix       = fix_q;

endmodule

// ===== hdl/rmo_check.sv =====
// Port-level checks for the rotation matrix orthonormaliser, and their bind.
// Sees only the top level ports. Depends on rmo_pkg.
module rmo_check (
	input logic          clk,
	input logic          arst_n,
	input logic          mat_valid,
	input logic          mat_stall,
	input rmo_pkg::mat_t mat,
	input logic          fix_valid,
	input logic          fix_stall,
	input rmo_pkg::fix_t fix
);
	import rmo_pkg::*;

	// hold a stalled result
	a_fix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && fix_stall |=> fix_valid && $stable(fix))
		else $error("stalled result dropped or changed");

	// hold a stalled request
	a_mat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && mat_stall |=> mat_valid && $stable(mat))
		else $error("stalled request dropped or changed");

	// input backpressure only while a result sits at the output
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		mat_stall |-> fix_valid)
		else $error("request stalled with no result waiting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mat_stall) |-> $past(fix_valid && fix_stall))
		else $error("request stall raised without output stall");

	// an OK status implies a nonzero repaired x column
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && fix.status == STAT_OK |->
			(fix.fix0_x != 0 || fix.fix0_y != 0 || fix.fix0_z != 0))
		else $error("status ok with zero x column");

endmodule

bind rotation_matrix_orthonormalise rmo_check u_rmo_check (.*);
